>>> hw/rtl/icv_pkg.sv
// ----------------------------------------------------------------------------
// icv_pkg
// Shared types, character codes and precedence helpers for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package icv_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Character codes
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_CARET  = 8'h5E;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_TERM   = 8'h00;

  // Precedence ranks: rank 0 stands for precedence -1
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;
  localparam logic [1:0] RANK_POW  = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_OPER
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    kind_t      kind;
    logic [1:0] rank;
  } work_item_t;

  typedef enum logic {
    BK_EXEC,
    BK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] stack_count;
    logic             flushing;
  } bk_status_t;

  function automatic logic [1:0] prec_rank(logic [7:0] c);
    logic [1:0] r;
    unique case (c)
      CHAR_PLUS, CHAR_MINUS: r = RANK_ADD;
      CHAR_STAR, CHAR_SLASH: r = RANK_MUL;
      CHAR_CARET:            r = RANK_POW;
      default:               r = RANK_NONE;
    endcase
    return r;
  endfunction

  function automatic kind_t classify(logic [7:0] c);
    kind_t k;
    priority if (c >= CHAR_ZERO && c <= CHAR_NINE) k = KIND_DIGIT;
    else if (c == CHAR_LPAREN) k = KIND_LPAREN;
    else if (c == CHAR_RPAREN) k = KIND_RPAREN;
    else k = KIND_OPER;
    return k;
  endfunction

endpackage

>>> hw/rtl/icv_ram.sv
// ----------------------------------------------------------------------------
// icv_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module icv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/icv_front.sv
// ----------------------------------------------------------------------------
// icv_front
// Accepts input characters, classifies them and holds them in a two-entry
// work queue for the back end.
// ----------------------------------------------------------------------------
module icv_front
  import icv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   item,
  output logic       wq_valid,
  output work_item_t wq_item,
  input  logic       wq_take
);

  work_item_t q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_count;
  logic       accept;
  work_item_t classified;

  // Classify the incoming character
  always_comb begin
    classified.ch   = item.ch;
    classified.last = item.end_of_expr;
    classified.kind = classify(item.ch);
    classified.rank = prec_rank(item.ch);
  end

  assign full     = (q_count == 2'd2);
  assign accept   = push && !full;
  assign wq_valid = (q_count != 2'd0);
  assign wq_item  = q_mem[rd_ptr];

  // Store accepted requests
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr] <= classified;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (wq_take) begin
        rd_ptr <= !rd_ptr;
      end
      q_count <= q_count + {1'b0, accept} - {1'b0, wq_take};
    end
  end

endmodule

>>> hw/rtl/icv_result_queue.sv
// ----------------------------------------------------------------------------
// icv_result_queue
// Two-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module icv_result_queue
  import icv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  out_item_t wr_item,
  output logic      res_full,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  out_item_t q_mem [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] q_count;
  logic      take;

  assign res_full = (q_count == 2'd2);
  assign empty    = (q_count == 2'd0);
  assign take     = pop && !empty;
  assign result   = q_mem[rd_ptr];

  // Store written results
  always_ff @(posedge clk) begin
    if (wr) begin
      q_mem[wr_ptr] <= wr_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      q_count <= q_count + {1'b0, wr} - {1'b0, take};
    end
  end

endmodule

>>> hw/rtl/icv_back.sv
// ----------------------------------------------------------------------------
// icv_back
// Executes classified characters on the operator stack, one push, pop or emit
// per cycle while results have room, and flushes the stack at expression end.
// ----------------------------------------------------------------------------
module icv_back
  import icv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wq_valid,
  input  work_item_t wq_item,
  output logic       wq_take,
  output logic       res_wr,
  output out_item_t  res_item,
  input  logic       res_full,
  output bk_status_t status
);

  back_state_t      state;
  back_state_t      state_next;
  logic [CNT_W-1:0] stack_count;
  logic [CNT_W-1:0] stack_count_next;
  logic [7:0]       top;
  logic [7:0]       top_next;
  logic             overflow_seen;
  logic             overflow_seen_next;

  logic             do_pop;
  logic             do_push;
  logic             main_done;
  logic             clr_ovf;
  logic             has_entry;
  logic             top_is_lparen;
  logic             stack_full;
  logic [1:0]       top_rank;
  logic [CNT_W-1:0] below_idx;
  logic [7:0]       ram_rdata;

  assign has_entry     = (stack_count != '0);
  assign top_is_lparen = (top == CHAR_LPAREN);
  assign stack_full    = (stack_count == CNT_W'(STACK_DEPTH));
  assign top_rank      = prec_rank(top);

  // Decide the action for this cycle
  always_comb begin
    do_pop    = 1'b0;
    do_push   = 1'b0;
    main_done = 1'b0;
    clr_ovf   = 1'b0;
    wq_take   = 1'b0;
    res_wr    = 1'b0;
    res_item.out_char = top;
    res_item.out_last = 1'b0;
    res_item.overflow = overflow_seen;
    if (wq_valid) begin
      unique case (state)
        BK_EXEC: begin
          unique case (wq_item.kind)
            KIND_DIGIT: begin
              if (!res_full) begin
                res_wr            = 1'b1;
                res_item.out_char = wq_item.ch;
                main_done         = 1'b1;
              end
            end
            KIND_LPAREN: begin
              do_push   = 1'b1;
              main_done = 1'b1;
            end
            KIND_RPAREN: begin
              if (has_entry && !top_is_lparen) begin
                if (!res_full) begin
                  do_pop = 1'b1;
                  res_wr = 1'b1;
                end
              end else begin
                do_pop    = has_entry;
                main_done = 1'b1;
              end
            end
            KIND_OPER: begin
              if (has_entry && wq_item.rank <= top_rank) begin
                if (!res_full) begin
                  do_pop = 1'b1;
                  res_wr = 1'b1;
                end
              end else begin
                do_push   = 1'b1;
                main_done = 1'b1;
              end
            end
            default: ;
          endcase
          wq_take = main_done && !wq_item.last;
        end
        BK_FLUSH: begin
          if (!res_full) begin
            res_wr = 1'b1;
            if (has_entry) begin
              do_pop = 1'b1;
            end else begin
              res_item.out_char = CHAR_TERM;
              res_item.out_last = 1'b1;
              clr_ovf           = 1'b1;
              wq_take           = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_EXEC:  if (main_done && wq_item.last) state_next = BK_FLUSH;
      BK_FLUSH: if (wq_take) state_next = BK_EXEC;
      default:  state_next = BK_EXEC;
    endcase
  end

  // Update stack pointer, cached top entry and overflow flag
  always_comb begin
    stack_count_next   = stack_count;
    top_next           = top;
    overflow_seen_next = overflow_seen;
    if (do_pop) begin
      stack_count_next = stack_count - CNT_W'(1);
      top_next         = ram_rdata;
    end else if (do_push) begin
      if (stack_full) begin
        overflow_seen_next = 1'b1;
      end else begin
        stack_count_next = stack_count + CNT_W'(1);
        top_next         = wq_item.ch;
      end
    end
    if (clr_ovf) begin
      overflow_seen_next = 1'b0;
    end
  end

  // Prefetch the entry below the next top
  assign below_idx = stack_count_next - CNT_W'(2);

  icv_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (do_push && !stack_full),
    .waddr (stack_count[ADDR_W-1:0]),
    .wdata (wq_item.ch),
    .raddr (below_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Hold the cached top entry
  always_ff @(posedge clk) begin
    top <= top_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_EXEC;
      stack_count   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      stack_count   <= stack_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  assign status.stack_count = stack_count;
  assign status.flushing    = (state == BK_FLUSH);

endmodule

>>> hw/rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard infix to postfix conversion, one character per request.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   input    | push / full      | item   : ch, end_of_expr
//   result   | empty / pop      | result : out_char, out_last, overflow
//
// A digit or a push is a single step in the back end; every stack pop that
// emits a character is a further step, and the end-of-expression flush
// pops each stacked entry in turn and then writes the terminator. The cached
// top entry and a prefetched read of the stack RAM allow one pop per cycle.
// Reset is synchronous and empties both queues and the stack at once.
// A full result queue stalls the back end; input is taken while the
// two-entry work queue has room.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
  import icv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic       wq_valid;
  work_item_t wq_item;
  logic       wq_take;
  logic       res_wr;
  out_item_t  res_item;
  logic       res_full;
  bk_status_t bk_status;

  icv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .wq_valid (wq_valid),
    .wq_item  (wq_item),
    .wq_take  (wq_take)
  );

  icv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .wq_valid (wq_valid),
    .wq_item  (wq_item),
    .wq_take  (wq_take),
    .res_wr   (res_wr),
    .res_item (res_item),
    .res_full (res_full),
    .status   (bk_status)
  );

  icv_result_queue u_results (
    .clk      (clk),
    .rst      (rst),
    .wr       (res_wr),
    .wr_item  (res_item),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  // Stack never grows past its depth
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    bk_status.stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // Back end writes results only into free space
  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> !res_full)
    else $error("result written into full queue");

  // Back end consumes only queued work
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    wq_take |-> wq_valid)
    else $error("work taken from empty queue");

  // Terminator writes happen only in the flush state with an empty stack
  a_term_flush: assert property (@(posedge clk) disable iff (rst)
    (res_wr && res_item.out_last) |->
      (bk_status.flushing && bk_status.stack_count == '0 &&
       res_item.out_char == CHAR_TERM))
    else $error("terminator outside flush");

  // Reset leaves both channels idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

>>> test/tb_infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Feeds infix expressions into the converter one character per request and
// checks each postfix result against an in-bench shunting-yard predictor:
// operator precedence, parentheses, stack flush with terminator, overflow flag
// handling, odd characters, and random well-formed and malformed expressions
// under bursty input and stalling output.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;
  import icv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_CHARS   = 120;
  localparam int SETTLE_CYCLES = STACK_DEPTH + 8;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_CHOPPY,
    RX_CRAWL
  } rx_mode_t;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  // Predictor state
  logic [7:0] op_stk[STACK_DEPTH];
  int         stk_depth;
  logic       ovf_pending;
  out_item_t  postfix_expect[$];

  // Expression under construction
  logic [7:0] expr_chars[$];

  // Traffic shaping and bookkeeping
  int       burst_left;
  rx_mode_t rx_mode = RX_STREAM;
  int       rx_mode_left = 0;
  int       fail_count;
  int       n_chars;
  int       n_exprs;
  int       n_results;
  int       n_ovf_results;

  infix_to_postfix_converter dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Shunting-yard predictor
  // ---------------------------------------------------------------------------
  function automatic int prec_level(logic [7:0] c);
    case (c)
      CHAR_PLUS, CHAR_MINUS: return 1;
      CHAR_STAR, CHAR_SLASH: return 2;
      CHAR_CARET:            return 3;
      default:               return -1;
    endcase
  endfunction

  function automatic void expect_char(logic [7:0] c, logic last);
    out_item_t r;
    r.out_char = c;
    r.out_last = last;
    r.overflow = ovf_pending;
    postfix_expect.push_back(r);
  endfunction

  function automatic void pop_to_output();
    expect_char(op_stk[stk_depth-1], 1'b0);
    stk_depth--;
  endfunction

  function automatic void stack_char(logic [7:0] c);
    if (stk_depth >= STACK_DEPTH) begin
      ovf_pending = 1'b1;
    end else begin
      op_stk[stk_depth] = c;
      stk_depth++;
    end
  endfunction

  function automatic void shunt_char(in_item_t it);
    int p;
    if (it.ch >= CHAR_ZERO && it.ch <= CHAR_NINE) begin
      expect_char(it.ch, 1'b0);
    end else if (it.ch == CHAR_LPAREN) begin
      stack_char(it.ch);
    end else if (it.ch == CHAR_RPAREN) begin
      while (stk_depth > 0 && op_stk[stk_depth-1] != CHAR_LPAREN) pop_to_output();
      if (stk_depth > 0) stk_depth--;
    end else begin
      p = prec_level(it.ch);
      while (stk_depth > 0 && p <= prec_level(op_stk[stk_depth-1])) pop_to_output();
      stack_char(it.ch);
    end
    // flush on end of expression, terminator carries the overflow flag
    if (it.end_of_expr) begin
      while (stk_depth > 0) pop_to_output();
      expect_char(CHAR_TERM, 1'b1);
      ovf_pending = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic last);
    in_item_t it;
    int       gap;
    bit       taken;
    it.ch          = c;
    it.end_of_expr = last;
    // open a new burst, sometimes after an idle gap
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    item <= it;
    // hold the request until full is low at a rising edge
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    shunt_char(it);
    n_chars++;
    if (last) n_exprs++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_expr_chars();
    for (int i = 0; i < expr_chars.size(); i++)
      send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  // Drop the request line and wait for every expected result, then settle
  task automatic hold_until_drained();
    push <= 1'b0;
    while (postfix_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(16, 96);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_STREAM: pop <= 1'b1;
      RX_CHOPPY: pop <= ($urandom_range(0, 3) != 0);
      default:   pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Sample at the falling edge: the result is taken at the next rising edge
  always @(negedge clk) begin
    out_item_t want;
    if (rst === 1'b0 && pop === 1'b1 && empty === 1'b0) begin
      if (postfix_expect.size() == 0) begin
        $error("unexpected result: out_char %02h out_last %0b overflow %0b",
               result.out_char, result.out_last, result.overflow);
        fail_count++;
      end else begin
        want = postfix_expect.pop_front();
        n_results++;
        if (want.overflow) n_ovf_results++;
        if (result.out_char !== want.out_char) begin
          $error("out_char: expected %02h, got %02h", want.out_char, result.out_char);
          fail_count++;
        end
        if (result.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, result.out_last);
          fail_count++;
        end
        if (result.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Expression builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_STAR;
      3:       return CHAR_SLASH;
      default: return CHAR_CARET;
    endcase
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 3))
      0:       return CHAR_LPAREN;
      1:       return CHAR_RPAREN;
      2:       return 8'(CHAR_ZERO + $urandom_range(0, 9));
      default: return pick_operator();
    endcase
  endfunction

  // Alternate operand and operator slots, nesting parens up to a small depth
  function automatic void build_wellformed();
    int  depth;
    int  target;
    bit  want_operand;
    expr_chars.delete();
    depth        = 0;
    want_operand = 1'b1;
    target       = $urandom_range(1, 14);
    forever begin
      if (want_operand) begin
        if (depth < 5 && $urandom_range(0, 3) == 0) begin
          expr_chars.push_back(CHAR_LPAREN);
          depth++;
        end else begin
          expr_chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
          want_operand = 1'b0;
        end
      end else begin
        if (depth == 0 && expr_chars.size() >= target) break;
        if (depth > 0 && ($urandom_range(0, 2) == 0 || expr_chars.size() >= target)) begin
          expr_chars.push_back(CHAR_RPAREN);
          depth--;
        end else begin
          expr_chars.push_back(pick_operator());
          want_operand = 1'b1;
        end
      end
    end
  endfunction

  // Break a well-formed expression: truncate it or corrupt one character
  function automatic void mangle_expr();
    int pos;
    if (expr_chars.size() > 1 && $urandom_range(0, 2) == 0) begin
      void'(expr_chars.pop_back());
    end else begin
      pos = $urandom_range(0, expr_chars.size() - 1);
      expr_chars[pos] = $urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255));
    end
  endfunction

  function automatic void build_noise();
    int len;
    expr_chars.delete();
    len = $urandom_range(1, 10);
    repeat (len) begin
      if ($urandom_range(0, 2) == 0) expr_chars.push_back(pick_special());
      else expr_chars.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every operator and both digit extremes in one expression
  task automatic test_precedence();
    send_text("0+9*1^2/3-4");
  endtask

  task automatic test_parens();
    send_text("(5-6)^7");
  endtask

  // Zero character, unknown operator popping a paren, unmatched close paren,
  // all-ones character, end marked on an open paren
  task automatic test_odd_chars();
    send_char(CHAR_LPAREN, 1'b0);
    send_char(CHAR_PLUS, 1'b0);
    send_char(CHAR_TERM, 1'b0);
    send_char(CHAR_RPAREN, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(CHAR_LPAREN, 1'b1);
  endtask

  // Overfill the stack, then flush a full stack right after the flag clears
  task automatic test_stack_overflow();
    repeat (STACK_DEPTH + 2) send_char(CHAR_LPAREN, 1'b0);
    send_char(8'(CHAR_ZERO + 7), 1'b0);
    send_char(CHAR_RPAREN, 1'b1);
    repeat (STACK_DEPTH) send_char(CHAR_LPAREN, 1'b0);
    send_char(8'(CHAR_ZERO + 3), 1'b1);
  endtask

  task automatic test_random_expressions();
    int start;
    int kind;
    bit drained;
    start   = n_chars;
    drained = 1'b0;
    while (n_chars - start < RAND_CHARS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        build_wellformed();
      end else if (kind < 9) begin
        build_wellformed();
        mangle_expr();
      end else begin
        build_noise();
      end
      send_expr_chars();
      // pause once mid-run until the block has gone quiet
      if (!drained && n_chars - start >= RAND_CHARS / 2) begin
        hold_until_drained();
        drained = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    item          = '0;
    burst_left    = 0;
    stk_depth     = 0;
    ovf_pending   = 1'b0;
    fail_count    = 0;
    n_chars       = 0;
    n_exprs       = 0;
    n_results     = 0;
    n_ovf_results = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_precedence();
    test_parens();
    test_odd_chars();
    hold_until_drained();
    test_stack_overflow();
    hold_until_drained();
    test_random_expressions();
    hold_until_drained();

    if (postfix_expect.size() != 0) begin
      $error("%0d expected results never arrived", postfix_expect.size());
      fail_count++;
    end
    $display("Sent %0d characters in %0d expressions; checked %0d postfix results,",
             n_chars, n_exprs, n_results);
    $display("%0d of them with the stack overflow flag set.", n_ovf_results);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
